// ===== hdl/crt_pair_combine_unit_macros.svh =====
// Assertion macros shared by the CRT pair combine unit.
// Depends on nothing; included by the top level.
`ifndef CRT_PAIR_COMBINE_UNIT_MACROS_SVH
`define CRT_PAIR_COMBINE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Implication with the consequent checked in the following cycle.
`define CPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== hdl/crtc_pkg.sv =====
// Package for the CRT pair combine unit: widths of moduli, results, divider operands and counters.
// Depends on nothing.
package crtc_pkg;
    localparam int MOD_BITS = 31;
    localparam int OUT_BITS = 62;
    localparam int DIV_BITS = 64;
    localparam int DCNT_BITS = 7;
endpackage

// ===== hdl/crt_pair_combine_unit.sv =====
// CRT pair combine unit: one item at a time on a shared restoring divider and a shift-add
// multiplier. A consistent item takes 11 divisions and 5 products, plus one division per
// gcd step and one division and one product per inverse step; a zero modulus goes straight
// to the result strobe. A new start is taken in the strobe cycle, so the next item can begin
// as soon as the last result is strobed; the receiver cannot stall. Reset clears all control
// state; no memories, no clearing pass.
`include "crt_pair_combine_unit_macros.svh"
module crt_pair_combine_unit
    import crtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [MOD_BITS-1:0] modulus_a,
    input  logic [MOD_BITS-1:0] residue_a,
    input  logic [MOD_BITS-1:0] modulus_b,
    input  logic [MOD_BITS-1:0] residue_b,
    output logic                strobe,
    output logic                consistent,
    output logic [OUT_BITS-1:0] combined_modulus,
    output logic [OUT_BITS-1:0] combined_residue
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RED   = 14'b00000000000010,
        S_GCD   = 14'b00000000000100,
        S_CHK   = 14'b00000000001000,
        S_DIVG  = 14'b00000000010000,
        S_SWAP  = 14'b00000000100000,
        S_INV   = 14'b00000001000000,
        S_KMUL  = 14'b00000010000000,
        S_KMOD  = 14'b00000100000000,
        S_LCM   = 14'b00001000000000,
        S_RES   = 14'b00010000000000,
        S_RES2  = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_MUL   = 14'b10000000000000
    } state_t;

    state_t              st_reg, st_next, ret_reg, ret_next;
    logic [3:0]          sub_reg, sub_next;
    logic                go;
    logic [DIV_BITS-1:0] dvd, dvs, quo, rem;
    logic                ddone;
    logic [DIV_BITS-1:0] m1_reg, m1_next, m2_reg, m2_next, r1_reg, r1_next;
    logic [DIV_BITS-1:0] r2_reg, r2_next, g_reg, g_next, rd_reg, rd_next;
    logic [DIV_BITS-1:0] a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic signed [DIV_BITS-1:0] t_reg, t_next, nt_reg, nt_next;
    // Shift-add multiplier state (one partial product per cycle).
    logic [DIV_BITS-1:0] mx_reg, mx_next, my_reg, my_next, mp_reg, mp_next;
    logic [DCNT_BITS-1:0] mc_reg, mc_next;
    logic                cons_reg, cons_next, stb_reg, stb_next;

    crtc_divider u_div (
        .clk(clk), .rst_n(rst_n), .go(go), .dividend(dvd), .divisor(dvs),
        .done(ddone), .quotient(quo), .remainder(rem)
    );

    // Sequencer: most sub steps issue a division or a multiply and wait for it.
    always_comb
    begin
        st_next = st_reg; ret_next = ret_reg; sub_next = sub_reg;
        go = 1'b0; dvd = '0; dvs = 64'd1;
        m1_next = m1_reg; m2_next = m2_reg; r1_next = r1_reg; r2_next = r2_reg;
        g_next = g_reg; rd_next = rd_reg; a_next = a_reg; b_next = b_reg;
        k_next = k_reg; t_next = t_reg; nt_next = nt_reg;
        mx_next = mx_reg; my_next = my_reg; mp_next = mp_reg; mc_next = mc_reg;
        cons_next = cons_reg; stb_next = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    m1_next = {33'd0, modulus_a}; r1_next = {33'd0, residue_a};
                    m2_next = {33'd0, modulus_b}; r2_next = {33'd0, residue_b};
                    sub_next = '0;
                    if (modulus_a == '0 || modulus_b == '0)
                    begin
                        cons_next = 1'b0; st_next = S_OUT;
                    end
                    else
                        st_next = S_RED;
                end
            end
            S_RED:
            begin
                // r1 %= m1, r2 %= m2.
                if (sub_reg == 4'd0) begin go = 1'b1; dvd = r1_reg; dvs = m1_reg;
                    sub_next = 4'd1; end
                else if (sub_reg == 4'd1) begin if (ddone) begin r1_next = rem;
                    sub_next = 4'd2; end end
                else if (sub_reg == 4'd2) begin go = 1'b1; dvd = r2_reg; dvs = m2_reg;
                    sub_next = 4'd3; end
                else if (ddone) begin r2_next = rem; a_next = m1_reg; b_next = m2_reg;
                    sub_next = 4'd0; st_next = S_GCD; end
            end
            S_GCD:
            begin
                if (sub_reg == 4'd0)
                begin
                    if (b_reg == '0) begin g_next = a_reg; st_next = S_CHK; end
                    else begin go = 1'b1; dvd = a_reg; dvs = b_reg; sub_next = 4'd1; end
                end
                else if (ddone) begin a_next = b_reg; b_next = rem; sub_next = 4'd0; end
            end
            S_CHK:
            begin
                if (sub_reg == 4'd0) begin go = 1'b1; dvd = r1_reg; dvs = g_reg;
                    sub_next = 4'd1; end
                else if (sub_reg == 4'd1) begin if (ddone) begin rd_next = rem;
                    r1_next = quo; sub_next = 4'd2; end end
                else if (sub_reg == 4'd2) begin go = 1'b1; dvd = r2_reg; dvs = g_reg;
                    sub_next = 4'd3; end
                else if (ddone)
                begin
                    r2_next = quo; sub_next = 4'd0;
                    if (rem != rd_reg) begin cons_next = 1'b0; st_next = S_OUT; end
                    else st_next = S_DIVG;
                end
            end
            S_DIVG:
            begin
                if (sub_reg == 4'd0) begin go = 1'b1; dvd = m1_reg; dvs = g_reg;
                    sub_next = 4'd1; end
                else if (sub_reg == 4'd1) begin if (ddone) begin m1_next = quo;
                    sub_next = 4'd2; end end
                else if (sub_reg == 4'd2) begin go = 1'b1; dvd = m2_reg; dvs = g_reg;
                    sub_next = 4'd3; end
                else if (ddone) begin m2_next = quo; sub_next = 4'd0; st_next = S_SWAP; end
            end
            S_SWAP:
            begin
                // Larger reduced modulus first; then k = (r2 - r1) mod m2.
                if (sub_reg == 4'd0)
                begin
                    if (m1_reg < m2_reg)
                    begin
                        m1_next = m2_reg; m2_next = m1_reg;
                        r1_next = r2_reg; r2_next = r1_reg;
                    end
                    sub_next = 4'd1;
                end
                else if (sub_reg == 4'd1) begin go = 1'b1; dvd = r1_reg; dvs = m2_reg;
                    sub_next = 4'd2; end
                else if (sub_reg == 4'd2) begin if (ddone) begin k_next = rem;
                    sub_next = 4'd3; end end
                else if (sub_reg == 4'd3) begin go = 1'b1; dvd = r2_reg; dvs = m2_reg;
                    sub_next = 4'd4; end
                else if (sub_reg == 4'd4) begin if (ddone) begin
                    k_next = rem + m2_reg - k_reg; sub_next = 4'd5; end end
                else if (sub_reg == 4'd5) begin go = 1'b1; dvd = k_reg; dvs = m2_reg;
                    sub_next = 4'd6; end
                else if (sub_reg == 4'd6) begin if (ddone) begin k_next = rem;
                    sub_next = 4'd7; end end
                else if (sub_reg == 4'd7)
                begin
                    // a holds r, b holds nr = m1 mod m2.
                    go = 1'b1; dvd = m1_reg; dvs = m2_reg; sub_next = 4'd8;
                end
                else if (ddone)
                begin
                    a_next = m2_reg; b_next = rem; t_next = '0; nt_next = 64'sd1;
                    sub_next = 4'd0; st_next = S_INV;
                end
            end
            S_INV:
            begin
                // Extended Euclid: one quotient per division, then (t, nt) becomes (nt, t - q * nt).
                if (sub_reg == 4'd0)
                begin
                    if (b_reg == '0)
                    begin
                        if (t_reg < 0) t_next = t_reg + $signed(m2_reg);
                        if (m2_reg == 64'd1) t_next = '0;
                        sub_next = 4'd0; st_next = S_KMUL;
                    end
                    else begin go = 1'b1; dvd = a_reg; dvs = b_reg; sub_next = 4'd1; end
                end
                else if (sub_reg == 4'd1)
                begin
                    if (ddone)
                    begin
                        a_next = b_reg; b_next = rem;
                        mx_next = quo; my_next = nt_reg; mp_next = '0;
                        mc_next = DCNT_BITS'(DIV_BITS);
                        ret_next = S_INV; sub_next = 4'd2; st_next = S_MUL;
                    end
                end
                else
                begin
                    t_next = nt_reg; nt_next = t_reg - $signed(mp_reg); sub_next = 4'd0;
                end
            end
            S_KMUL:
            begin
                mx_next = k_reg; my_next = t_reg; mp_next = '0;
                mc_next = DCNT_BITS'(DIV_BITS); ret_next = S_KMOD; sub_next = 4'd0;
                st_next = S_MUL;
            end
            S_KMOD:
            begin
                if (sub_reg == 4'd0) begin go = 1'b1; dvd = mp_reg; dvs = m2_reg;
                    sub_next = 4'd1; end
                else if (ddone)
                begin
                    k_next = rem; mx_next = m1_reg; my_next = m2_reg; mp_next = '0;
                    mc_next = DCNT_BITS'(DIV_BITS); ret_next = S_LCM; sub_next = 4'd0;
                    st_next = S_MUL;
                end
            end
            S_LCM:
            begin
                // m1*m2 then *g -> combined modulus held in a; then k*m1 is started.
                if (sub_reg == 4'd0)
                begin
                    mx_next = mp_reg; my_next = g_reg; mp_next = '0;
                    mc_next = DCNT_BITS'(DIV_BITS); sub_next = 4'd1; st_next = S_MUL;
                end
                else
                begin
                    a_next = mp_reg; mx_next = k_reg; my_next = m1_reg; mp_next = '0;
                    mc_next = DCNT_BITS'(DIV_BITS); ret_next = S_RES; sub_next = 4'd0;
                    st_next = S_MUL;
                end
            end
            S_RES:
            begin
                mx_next = mp_reg + r1_reg; my_next = g_reg; mp_next = '0;
                mc_next = DCNT_BITS'(DIV_BITS); ret_next = S_RES2; st_next = S_MUL;
            end
            S_RES2:
            begin
                b_next = mp_reg + rd_reg; cons_next = 1'b1; st_next = S_OUT;
            end
            S_MUL:
            begin
                // Shift-add: one bit of the multiplier a cycle.
                if (my_reg[0]) mp_next = mp_reg + mx_reg;
                mx_next = {mx_reg[DIV_BITS-2:0], 1'b0};
                my_next = {1'b0, my_reg[DIV_BITS-1:1]};
                mc_next = mc_reg - 1'b1;
                if (mc_reg == DCNT_BITS'(1)) st_next = ret_reg;
            end
            S_OUT:
            begin
                stb_next = 1'b1; st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ret_reg <= S_IDLE; sub_reg <= '0;
            stb_reg <= 1'b0; cons_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ret_reg <= ret_next; sub_reg <= sub_next;
            stb_reg <= stb_next; cons_reg <= cons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= m1_next; m2_reg <= m2_next; r1_reg <= r1_next; r2_reg <= r2_next;
        g_reg <= g_next; rd_reg <= rd_next; a_reg <= a_next; b_reg <= b_next;
        k_reg <= k_next; t_reg <= t_next; nt_reg <= nt_next;
        mx_reg <= mx_next; my_reg <= my_next; mp_reg <= mp_next; mc_reg <= mc_next;
    end

    assign busy             = (st_reg != S_IDLE);
    assign strobe           = stb_reg;
    assign consistent       = cons_reg;
    assign combined_modulus = cons_reg ? a_reg[OUT_BITS-1:0] : '0;
    assign combined_residue = cons_reg ? b_reg[OUT_BITS-1:0] : '0;

    `CPC_ASSERT_NEXT(a_out_strobe, st_reg == S_OUT, strobe && !busy)
    `CPC_ASSERT_IMP(a_strobe_idle, strobe, st_reg == S_IDLE)
    `CPC_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `CPC_ASSERT_IMP(a_cons_only_out, strobe && !consistent, combined_modulus == '0)
endmodule

// ===== hdl/crtc_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on crtc_pkg.
module crtc_divider
    import crtc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quotient,
    output logic [DIV_BITS-1:0] remainder
);
    logic [DIV_BITS-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next, done_reg, done_next;
    logic [DIV_BITS:0]    trial;

    // One shift-subtract step per cycle while running.
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[DIV_BITS-1]} - {1'b0, d_reg};
        if (go)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = DCNT_BITS'(DIV_BITS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DIV_BITS])
                r_next = trial[DIV_BITS-1:0];
            else
                r_next = {r_reg[DIV_BITS-2:0], q_reg[DIV_BITS-1]};
            q_next   = {q_reg[DIV_BITS-2:0], ~trial[DIV_BITS]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_BITS'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// ===== tb/tb_crt_pair_combine_unit.sv =====
// Self-checking testbench for the CRT pair combine unit: directed table, then random pairs.
// Depends on crtc_pkg and the crt_pair_combine_unit RTL; needs no files at run time.
module tb_crt_pair_combine_unit;
    import crtc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM   = 130;
    localparam int  CYCLE_LIMIT = 10000000;
    localparam logic [MOD_BITS-1:0] MOD_MAX = {MOD_BITS{1'b1}};

    typedef struct packed {
        logic [MOD_BITS-1:0] ma;
        logic [MOD_BITS-1:0] ra;
        logic [MOD_BITS-1:0] mb;
        logic [MOD_BITS-1:0] rb;
    } pair_t;

    typedef struct packed {
        logic                ok;
        logic [OUT_BITS-1:0] lcm;
        logic [OUT_BITS-1:0] sol;
    } crt_res_t;

    typedef struct packed {
        pair_t    p;
        logic     typed;
        crt_res_t r;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [MOD_BITS-1:0] modulus_a;
    logic [MOD_BITS-1:0] residue_a;
    logic [MOD_BITS-1:0] modulus_b;
    logic [MOD_BITS-1:0] residue_b;
    logic                strobe;
    logic                consistent;
    logic [OUT_BITS-1:0] combined_modulus;
    logic [OUT_BITS-1:0] combined_residue;

    crt_res_t solution_queue[$];
    int       n_errors;
    int       n_results;
    int       n_sent;
    int       n_inconsistent;
    longint   cycle_count;
    dir_row_t dir_table[$];

    crt_pair_combine_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .modulus_a        (modulus_a),
        .residue_a        (residue_a),
        .modulus_b        (modulus_b),
        .residue_b        (residue_b),
        .strobe           (strobe),
        .consistent       (consistent),
        .combined_modulus (combined_modulus),
        .combined_residue (combined_residue)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Greatest common divisor by repeated remainder.
    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Inverse of a modulo m by extended Euclid; zero when m is one.
    function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] m);
        longint t, nt, r, nr, q, tmp;
        t  = 0;
        nt = 1;
        r  = longint'(m);
        nr = longint'(a % m);
        while (nr != 0)
        begin
            q   = r / nr;
            tmp = t - q * nt;
            t   = nt;
            nt  = tmp;
            tmp = r - q * nr;
            r   = nr;
            nr  = tmp;
        end
        t = t % longint'(m);
        if (t < 0)
            t = t + longint'(m);
        return 64'(t);
    endfunction

    // Predicts the combined congruence for one pair.
    function automatic crt_res_t combine_pair(pair_t p);
        crt_res_t    res;
        logic [63:0] m1, r1, m2, r2, g, rd, k, inv, t;
        res = '0;
        m1 = 64'(p.ma);
        r1 = 64'(p.ra);
        m2 = 64'(p.mb);
        r2 = 64'(p.rb);
        if (m1 == 0 || m2 == 0)
            return res;
        r1 = r1 % m1;
        r2 = r2 % m2;
        g  = gcd64(m1, m2);
        if (r1 % g != r2 % g)
            return res;
        rd = r1 % g;
        m1 = m1 / g;
        m2 = m2 / g;
        r1 = r1 / g;
        r2 = r2 / g;
        if (m1 < m2)
        begin
            t = m1; m1 = m2; m2 = t;
            t = r1; r1 = r2; r2 = t;
        end
        k   = (r2 % m2 + m2 - r1 % m2) % m2;
        inv = mod_inverse(m1, m2);
        k   = (k * inv) % m2;
        res.ok  = 1'b1;
        res.lcm = OUT_BITS'(m1 * m2 * g);
        res.sol = OUT_BITS'((k * m1 + r1) * g + rd);
        return res;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 n_results);
    endtask

    // Result checker: compares every strobed transfer with the oldest expectation.
    always @(posedge clk)
    begin
        crt_res_t want;
        if (rst_n && strobe)
        begin
            if (solution_queue.size() == 0)
            begin
                n_errors++;
                $display("MISMATCH: result transfer with nothing expected");
            end
            else
            begin
                want = solution_queue.pop_front();
                if (consistent !== want.ok)
                    report_mismatch("consistent", 64'(consistent), 64'(want.ok));
                if (combined_modulus !== want.lcm)
                    report_mismatch("combined_modulus", 64'(combined_modulus), 64'(want.lcm));
                if (combined_residue !== want.sol)
                    report_mismatch("combined_residue", 64'(combined_residue), 64'(want.sol));
                if (!want.ok)
                    n_inconsistent++;
            end
            n_results++;
        end
    end

    // Watchdog on total cycles.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Random modulus: often small, sometimes full width, sometimes a product that may share a factor.
    function automatic logic [MOD_BITS-1:0] rand_modulus(int sel);
        logic [MOD_BITS-1:0] m;
        if (sel < 40)
            m = MOD_BITS'($urandom_range(1, 1000));
        else if (sel < 70)
            m = MOD_BITS'($urandom);
        else
            m = MOD_BITS'($urandom_range(1, 4000)) * MOD_BITS'($urandom_range(1, 30));
        if (m == 0)
            m = 1;
        return m;
    endfunction

    // Builds a random pair; most are consistent by construction.
    function automatic pair_t rand_pair();
        pair_t       p;
        logic [63:0] x;
        int          sel;
        sel  = $urandom_range(0, 99);
        p.ma = rand_modulus($urandom_range(0, 99));
        p.mb = rand_modulus($urandom_range(0, 99));
        if (sel < 8)
        begin
            p.ma = MOD_BITS'($urandom);
            p.mb = MOD_BITS'($urandom);
            p.ra = MOD_BITS'($urandom);
            p.rb = MOD_BITS'($urandom);
        end
        else if (sel < 70)
        begin
            x    = {$urandom, $urandom};
            p.ra = MOD_BITS'(x % 64'(p.ma));
            p.rb = MOD_BITS'(x % 64'(p.mb));
        end
        else
        begin
            p.ra = MOD_BITS'(64'($urandom) % 64'(p.ma));
            p.rb = MOD_BITS'(64'($urandom) % 64'(p.mb));
        end
        return p;
    endfunction

    // Drives one pair after random idle cycles and holds it until the start transfer
    // is accepted; start is left high, so the caller lowers it when nothing follows.
    task automatic send_pair(pair_t p, logic quiet);
        while (!quiet && $urandom_range(0, 99) < 26)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        modulus_a <= p.ma;
        residue_a <= p.ra;
        modulus_b <= p.mb;
        residue_b <= p.rb;
        start     <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        solution_queue.insert(solution_queue.size(), combine_pair(p));
        n_sent++;
    endtask

    function automatic dir_row_t row(logic [MOD_BITS-1:0] ma, logic [MOD_BITS-1:0] ra,
                                     logic [MOD_BITS-1:0] mb, logic [MOD_BITS-1:0] rb,
                                     logic typed, logic ok, logic [OUT_BITS-1:0] lcm,
                                     logic [OUT_BITS-1:0] sol);
        dir_row_t d;
        d.p     = '{ma, ra, mb, rb};
        d.typed = typed;
        d.r     = '{ok, lcm, sol};
        return d;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(dir_row_t d);
        dir_table.insert(dir_table.size(), d);
    endtask

    // Stimulus: directed table, random pairs, then drain.
    initial
    begin
        int wait_cycles;
        rst_n     = 1'b0;
        start     = 1'b0;
        modulus_a = '0;
        residue_a = '0;
        modulus_b = '0;
        residue_b = '0;
        n_errors = 0;
        n_results = 0;
        n_sent = 0;
        n_inconsistent = 0;
        cycle_count = 0;

        // Directed rows: extremes, zero moduli, unreduced residues, disagreement.
        add_row(row(1, 0, 1, 0, 1, 1, 1, 0));
        add_row(row(0, 0, 5, 3, 1, 0, 0, 0));
        add_row(row(7, 2, 0, 0, 1, 0, 0, 0));
        add_row(row(0, MOD_MAX, 0, MOD_MAX, 1, 0, 0, 0));
        add_row(row(4, 1, 6, 2, 1, 0, 0, 0));
        add_row(row(6, 3, 6, 3, 1, 1, 6, 3));
        add_row(row(6, 3, 6, 4, 1, 0, 0, 0));
        add_row(row(MOD_MAX, MOD_MAX - 1, MOD_MAX, MOD_MAX - 1, 1, 1,
                    OUT_BITS'(MOD_MAX), OUT_BITS'(MOD_MAX - 1)));
        add_row(row(MOD_MAX, 0, MOD_MAX, 0, 1, 1, OUT_BITS'(MOD_MAX), 0));
        add_row(row(3, 2, 5, 3, 1, 1, 15, 8));
        add_row(row(5, 3, 3, 2, 0, 0, 0, 0));
        add_row(row(4, 3, 6, 5, 0, 0, 0, 0));
        add_row(row(10, 17, 4, 9, 0, 0, 0, 0));
        add_row(row(MOD_MAX, MOD_MAX, 2, 5, 0, 0, 0, 0));
        add_row(row(MOD_MAX, 12345, MOD_MAX - 1, 999, 0, 0, 0, 0));
        add_row(row(MOD_MAX - 1, MOD_MAX - 2, 2, 1, 0, 0, 0, 0));
        add_row(row(1, MOD_MAX, MOD_MAX, 0, 0, 0, 0, 0));
        add_row(row(12, 5, 1, 0, 0, 0, 0, 0));
        add_row(row(1 << 30, (1 << 30) - 1, 3, 1, 0, 0, 0, 0));
        add_row(row(MOD_BITS'(32'h2AAAAAAA), MOD_BITS'(32'h15555555),
                    MOD_BITS'(32'h55555555), MOD_BITS'(32'h2AAAAAAA),
                    0, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Typed rows must also agree with the predictor.
        foreach (dir_table[i])
        begin
            if (dir_table[i].typed && combine_pair(dir_table[i].p) !== dir_table[i].r)
            begin
                n_errors++;
                $display("MISMATCH: directed row %0d disagrees with its typed result", i);
            end
            send_pair(dir_table[i].p, 1'b0);
        end
        start <= 1'b0;

        // Hold off until the directed results have all arrived.
        while (solution_queue.size() != 0)
            @(posedge clk);

        // Random pairs; the middle stretch runs without idling.
        for (int i = 0; i < N_RANDOM; i++)
            send_pair(rand_pair(), (i >= 50 && i < 90));
        start <= 1'b0;

        wait_cycles = 0;
        while (solution_queue.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        $display("Covered %0d pairs (%0d results, %0d flagged inconsistent), %0d cycles.",
                 n_sent, n_results, n_inconsistent, cycle_count);
        if (n_errors == 0 && solution_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
